FILE: hdl/tga_pkg.sv
// Shared types, widths and codes for the timestamp group aggregator.
// No dependencies; every other file of the block imports this package.
package tga_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_GROUP = 64;
  localparam int VAL_W     = 48;
  localparam int SMP_W     = 32;
  localparam int TIME_W    = 48;
  localparam int CNT_W     = 7;
  localparam int FACT_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * FACT_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] GROUP_MAX = CNT_W'(MAX_GROUP);

  localparam logic signed [VAL_W-1:0] Q_ONE     = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] MINUS_ONE = -Q_ONE;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [FACT_W-1:0] SCALE_RESET = FACT_W'(1) << FRAC_BITS;

  // Fold modes
  localparam logic [1:0] FOLD_AVG = 2'd0;
  localparam logic [1:0] FOLD_SUM = 2'd1;
  localparam logic [1:0] FOLD_MIN = 2'd2;
  localparam logic [1:0] FOLD_MAX = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_FOLD_MODE   = 3'd0;
  localparam logic [2:0] REG_IS_ENERGY   = 3'd1;
  localparam logic [2:0] REG_ENERGY_UNIT = 3'd2;
  localparam logic [2:0] REG_SCALE       = 3'd3;
  localparam logic [2:0] REG_EMIT_ENABLE = 3'd4;

  typedef struct packed {
    logic signed [SMP_W-1:0] value;
    logic                    is_new;
  } tga_item_t;

  typedef struct packed {
    logic [1:0]        fold_mode;
    logic              is_energy;
    logic [FACT_W-1:0] energy_unit;
    logic [FACT_W-1:0] scale_factor;
    logic              emit_enable;
  } tga_cfg_t;

endpackage

FILE: hdl/timestamp_group_aggregator.sv
// Path: an accepted beat is queued in tga_front, popped by tga_back, divided in tga_div when
// it completes an average group, scaled once (twice with energy) and loaded as the result.
// The back end takes one item at a time and pops the next only once its result is loaded;
// the pace is set by the shared 32x32 multiplier in tga_scale and the divider in tga_div.
// Reset: synchronous active-low rst_n clears the queue, group state and the registers
// to their reset values; the block takes beats on the first cycle after reset.
module timestamp_group_aggregator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [tga_pkg::ADDR_W-1:0] paddr,
  input  logic        [tga_pkg::DATA_W-1:0] pwdata,
  output logic        [tga_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  // Sample input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tga_pkg::SMP_W-1:0]  in_sample_value,
  input  logic        [tga_pkg::TIME_W-1:0] in_sample_time,
  // Result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_emit_valid,
  output logic signed [tga_pkg::VAL_W-1:0]  out_emit_value,
  output logic                              out_latest_ready,
  output logic signed [tga_pkg::VAL_W-1:0]  out_latest_value
);
  import tga_pkg::*;

  tga_cfg_t   cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       q_valid, q_pop;
  tga_item_t  q_item;

  // Registers sit on word boundaries; the low two address bits are ignored
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fold_mode    <= FOLD_AVG;
      cfg_r.is_energy    <= 1'b0;
      cfg_r.energy_unit  <= '0;
      cfg_r.scale_factor <= SCALE_RESET;
      cfg_r.emit_enable  <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FOLD_MODE:   cfg_r.fold_mode    <= pwdata[1:0];
        REG_IS_ENERGY:   cfg_r.is_energy    <= pwdata[0];
        REG_ENERGY_UNIT: cfg_r.energy_unit  <= pwdata;
        REG_SCALE:       cfg_r.scale_factor <= pwdata;
        REG_EMIT_ENABLE: cfg_r.emit_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back; unmapped addresses return zero
  always_comb begin
    case (reg_idx)
      REG_FOLD_MODE:   prdata = DATA_W'(cfg_r.fold_mode);
      REG_IS_ENERGY:   prdata = DATA_W'(cfg_r.is_energy);
      REG_ENERGY_UNIT: prdata = cfg_r.energy_unit;
      REG_SCALE:       prdata = cfg_r.scale_factor;
      REG_EMIT_ENABLE: prdata = DATA_W'(cfg_r.emit_enable);
      default:         prdata = '0;
    endcase
  end

  // Front: accept beats, tag new versus repeated timestamps, hold them in a short queue
  tga_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_sample_time  (in_sample_time),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back: fold into the group, divide on average completion, scale, present the result
  tga_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_emit_valid   (out_emit_valid),
    .out_emit_value   (out_emit_value),
    .out_latest_ready (out_latest_ready),
    .out_latest_value (out_latest_value)
  );

endmodule

FILE: hdl/tga_front.sv
// Front end: takes input beats, marks each as a new or repeated timestamp,
// and queues them for the back end. Depends on tga_pkg.
module tga_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [tga_pkg::SMP_W-1:0]  in_sample_value,
  input  logic        [tga_pkg::TIME_W-1:0] in_sample_time,
  output logic                         q_valid,
  output tga_pkg::tga_item_t           q_item,
  input  logic                         q_pop
);
  import tga_pkg::*;

  tga_item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wptr_r, rptr_r;
  logic [Q_AW:0]     fill_r;
  logic [TIME_W-1:0] last_time_r;
  logic              push, pop, full;

  assign full     = (fill_r == (Q_AW+1)'(Q_DEPTH));
  assign in_stall = full;
  assign push     = in_valid && !full;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r].value  <= in_sample_value;
      mem_r[wptr_r].is_new <= (in_sample_time != last_time_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      fill_r      <= '0;
      last_time_r <= '0;
    end else begin
      if (push) begin
        wptr_r      <= wptr_r + 1'b1;
        last_time_r <= in_sample_time;
      end
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

FILE: hdl/tga_div.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating.
// Divides the group sum by the group size. Depends on tga_pkg.
module tga_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [tga_pkg::VAL_W-1:0] dividend,
  input  logic        [tga_pkg::CNT_W-1:0] divisor,
  output logic                             done,
  output logic signed [tga_pkg::VAL_W-1:0] quotient
);
  import tga_pkg::*;

  localparam int IT_W = $clog2(VAL_W);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]              state_r;
  logic [IT_W-1:0]         it_r;
  logic [CNT_W:0]          rem_r, rem_sh, den;
  logic [VAL_W-1:0]        q_r;
  logic [CNT_W-1:0]        den_r;
  logic                    neg_r, done_r;
  logic signed [VAL_W-1:0] quot_r;

  assign den    = {1'b0, den_r};
  assign rem_sh = {rem_r[CNT_W-1:0], q_r[VAL_W-1]};
  assign done     = done_r;
  assign quotient = quot_r;

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[VAL_W-1];
      q_r   <= dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
      rem_r <= '0;
      den_r <= divisor;
    end else if (state_r == D_RUN) begin
      if (rem_sh >= den) begin
        rem_r <= rem_sh - den;
        q_r   <= {q_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[VAL_W-2:0], 1'b0};
      end
    end
    if (state_r == D_FIN) quot_r <= neg_r ? -$signed(q_r) : $signed(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      it_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            state_r <= D_RUN;
            it_r    <= '0;
          end
        end
        D_RUN: begin
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(VAL_W-1)) state_r <= D_FIN;
        end
        D_FIN: begin
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/tga_scale.sv
// Fixed-point scaler: one or two saturating Q multiplies through a shared
// 32x32 multiplier, low and high halves in turn. Depends on tga_pkg.
module tga_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [tga_pkg::VAL_W-1:0]  x,
  input  logic                              use_energy,
  input  logic        [tga_pkg::FACT_W-1:0] energy_unit,
  input  logic        [tga_pkg::FACT_W-1:0] scale_factor,
  output logic                              done,
  output logic signed [tga_pkg::VAL_W-1:0]  result
);
  import tga_pkg::*;

  localparam logic [2:0] SC_IDLE = 3'd0;
  localparam logic [2:0] SC_ABS  = 3'd1;
  localparam logic [2:0] SC_LO   = 3'd2;
  localparam logic [2:0] SC_HI   = 3'd3;
  localparam logic [2:0] SC_CMB  = 3'd4;
  localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (VAL_W-1);

  logic [2:0]              state_r;
  logic                    pass_r, neg_r, done_r;
  logic signed [VAL_W-1:0] x_r, sat;
  logic [VAL_W-1:0]        mag_r;
  logic [PROD_W-1:0]       a_r, b_r, prod, r, rr;
  logic [FACT_W-1:0]       f, mul_a;
  logic                    ovf;

  assign f     = pass_r ? scale_factor : energy_unit;
  assign mul_a = (state_r == SC_LO) ? mag_r[FACT_W-1:0]
                                    : FACT_W'(mag_r[VAL_W-1:FACT_W]);
  assign prod  = {{FACT_W{1'b0}}, mul_a} * {{FACT_W{1'b0}}, f};

  // Recombine the halves, truncate the fraction, saturate to the result width
  always_comb begin
    ovf = (b_r >> (15 + FRAC_BITS)) != '0;
    r   = (b_r << (32 - FRAC_BITS)) + (a_r >> FRAC_BITS);
    rr  = ovf ? LIM : r;
    if (neg_r) sat = (rr >= LIM) ? VAL_MIN : -$signed(rr[VAL_W-1:0]);
    else       sat = (rr > PROD_W'(VAL_MAX)) ? VAL_MAX : $signed(rr[VAL_W-1:0]);
  end

  assign done   = done_r;
  assign result = x_r;

  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: if (start) x_r <= x;
      SC_ABS: begin
        neg_r <= x_r[VAL_W-1];
        mag_r <= x_r[VAL_W-1] ? VAL_W'(-x_r) : VAL_W'(x_r);
      end
      SC_LO:  a_r <= prod;
      SC_HI:  b_r <= prod;
      SC_CMB: x_r <= sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      pass_r  <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        SC_IDLE: begin
          if (start) begin
            pass_r  <= !use_energy;
            state_r <= SC_ABS;
          end
        end
        SC_ABS: state_r <= SC_LO;
        SC_LO:  state_r <= SC_HI;
        SC_HI:  state_r <= SC_CMB;
        SC_CMB: begin
          if (pass_r) begin
            done_r  <= 1'b1;
            state_r <= SC_IDLE;
          end else begin
            pass_r  <= 1'b1;
            state_r <= SC_ABS;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/tga_back.sv
// Back end: group state, fold, completion, divide and scale sequencing,
// and the result register. Depends on tga_pkg, tga_div and tga_scale.
module tga_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tga_pkg::tga_cfg_t                cfg,
  input  logic                             q_valid,
  input  tga_pkg::tga_item_t               q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_emit_valid,
  output logic signed [tga_pkg::VAL_W-1:0] out_emit_value,
  output logic                             out_latest_ready,
  output logic signed [tga_pkg::VAL_W-1:0] out_latest_value
);
  import tga_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_DIV   = 3'd1;
  localparam logic [2:0] B_SCALE = 3'd2;
  localparam logic [2:0] B_WAIT  = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]              state_r;
  logic signed [VAL_W-1:0] running_r, running_nxt;
  logic signed [VAL_W-1:0] latched_r, latched_nxt;
  logic [1:0]              seen_r, seen_nxt;
  logic [CNT_W-1:0]        size_r, size_nxt, cnt_r, cnt_nxt;
  logic                    lvalid_r, lvalid_nxt, emit_r, emit_nxt;
  logic                    need_div, counted, done;
  logic signed [VAL_W-1:0] v48;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] sum_c;

  logic                    usable, ready, load;
  logic                    div_done, scale_done;
  logic signed [VAL_W-1:0] div_q, scale_res;

  logic                    out_valid_r, out_emit_valid_r, out_latest_ready_r;
  logic signed [VAL_W-1:0] out_emit_value_r, out_latest_value_r;

  assign q_pop  = (state_r == B_IDLE) && q_valid;
  assign v48    = VAL_W'(q_item.value);
  assign sum    = (VAL_W+1)'(running_r) + (VAL_W+1)'(v48);
  assign sum_c  = (sum[VAL_W] != sum[VAL_W-1]) ? (sum[VAL_W] ? VAL_MIN : VAL_MAX)
                                               : sum[VAL_W-1:0];
  assign usable = !cfg.is_energy || (cfg.energy_unit != '0);

  // Group bookkeeping for one popped item
  always_comb begin
    running_nxt = running_r;
    latched_nxt = latched_r;
    seen_nxt    = seen_r;
    size_nxt    = size_r;
    cnt_nxt     = cnt_r;
    lvalid_nxt  = lvalid_r;
    emit_nxt    = emit_r;
    need_div    = 1'b0;
    counted     = 1'b0;
    done        = 1'b0;
    if (q_pop) begin
      emit_nxt = 1'b0;
      if (q_item.is_new) begin
        running_nxt = v48;
        if (!seen_r[1]) seen_nxt = seen_r + 2'd1;
        cnt_nxt  = CNT_W'(1);
        emit_nxt = seen_nxt[1] && (size_r == CNT_W'(1));
      end else begin
        counted = (cnt_r < COUNT_TOP);
        if (counted) cnt_nxt = cnt_r + 1'b1;
        if (seen_r == 2'd1) begin
          if (size_r < GROUP_MAX) size_nxt = size_r + 1'b1;
        end else begin
          done = counted && (cnt_nxt == size_r);
          case (cfg.fold_mode)
            FOLD_AVG: begin
              running_nxt = sum_c;
              need_div    = done;
            end
            FOLD_SUM: begin
              running_nxt = sum_c;
              if (done) latched_nxt = sum_c;
            end
            FOLD_MIN: begin
              if (running_r > v48) running_nxt = v48;
              if (done) latched_nxt = running_nxt;
            end
            default: begin
              if (running_r < v48) running_nxt = v48;
              if (done) latched_nxt = running_nxt;
            end
          endcase
          if (done) begin
            lvalid_nxt = 1'b1;
            emit_nxt   = 1'b1;
          end
        end
      end
    end
  end

  tga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (need_div),
    .dividend (running_nxt),
    .divisor  (size_r),
    .done     (div_done),
    .quotient (div_q)
  );

  tga_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (state_r == B_SCALE),
    .x            ((size_r > CNT_W'(1)) ? latched_r : running_r),
    .use_energy   (cfg.is_energy && (cfg.energy_unit != '0)),
    .energy_unit  (cfg.energy_unit),
    .scale_factor (cfg.scale_factor),
    .done         (scale_done),
    .result       (scale_res)
  );

  assign ready = seen_r[1] && usable && ((size_r <= CNT_W'(1)) || lvalid_r);
  assign load  = (state_r == B_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      running_r <= MINUS_ONE;
      latched_r <= MINUS_ONE;
      seen_r    <= '0;
      size_r    <= CNT_W'(1);
      cnt_r     <= '0;
      lvalid_r  <= 1'b0;
      emit_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      seen_r    <= seen_nxt;
      size_r    <= size_nxt;
      cnt_r     <= cnt_nxt;
      lvalid_r  <= lvalid_nxt;
      emit_r    <= emit_nxt;
      latched_r <= (state_r == B_DIV && div_done) ? div_q : latched_nxt;
      case (state_r)
        B_IDLE:  if (q_pop) state_r <= need_div ? B_DIV : B_SCALE;
        B_DIV:   if (div_done) state_r <= B_SCALE;
        B_SCALE: state_r <= B_WAIT;
        B_WAIT:  if (scale_done) state_r <= B_OUT;
        B_OUT:   if (load) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_emit_valid_r   <= emit_r && cfg.emit_enable && usable;
      out_emit_value_r   <= (emit_r && cfg.emit_enable && usable) ? scale_res : '0;
      out_latest_ready_r <= ready;
      out_latest_value_r <= scale_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_emit_valid   = out_emit_valid_r;
  assign out_emit_value   = out_emit_value_r;
  assign out_latest_ready = out_latest_ready_r;
  assign out_latest_value = out_latest_value_r;

endmodule

FILE: hdl/tga_checker.sv
// Port-level checks for the aggregator, attached to the top level by bind.
// Depends on tga_pkg and timestamp_group_aggregator.
module tga_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              pready,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_emit_valid,
  input logic signed [tga_pkg::VAL_W-1:0]  out_emit_value,
  input logic                              out_latest_ready,
  input logic signed [tga_pkg::VAL_W-1:0]  out_latest_value
);
  import tga_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_latest_value)
      && $stable(out_emit_value) && $stable(out_emit_valid))
    else $error("result beat changed while stalled");

  // Drop the emitted value to zero when nothing is emitted
  a_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_emit_valid |-> out_emit_value == '0)
    else $error("emit value not zero without emission");

  // An emitted value is the same scaled value as the latest one
  a_emit_latest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_valid |-> out_emit_value == out_latest_value)
    else $error("emit value differs from latest value");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind timestamp_group_aggregator tga_checker u_tga_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for the timestamp group aggregator: directed and random sample beats,
// register writes with read-back, and a per-sample predictor compared against every result.
// Depends on tga_pkg and timestamp_group_aggregator only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tga_pkg::*;

  localparam int ITEM_TARGET    = 650;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected result beat, laid out as the output ports.
  typedef struct packed {
    logic                    emit_valid;
    logic signed [VAL_W-1:0] emit_value;
    logic                    latest_ready;
    logic signed [VAL_W-1:0] latest_value;
  } agg_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic signed [SMP_W-1:0]  in_sample_value = '0;
  logic        [TIME_W-1:0] in_sample_time  = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_emit_valid;
  logic signed [VAL_W-1:0] out_emit_value;
  logic                    out_latest_ready;
  logic signed [VAL_W-1:0] out_latest_value;

  timestamp_group_aggregator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_sample_time   (in_sample_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_emit_valid   (out_emit_valid),
    .out_emit_value   (out_emit_value),
    .out_latest_ready (out_latest_ready),
    .out_latest_value (out_latest_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the grouping state,
  // starting from the reset values.
  // ---------------------------------------------------------------------------
  tga_cfg_t cfg_model = '{fold_mode: FOLD_AVG, is_energy: 1'b0, energy_unit: '0,
                          scale_factor: SCALE_RESET, emit_enable: 1'b1};

  longint             acc_value    = longint'(MINUS_ONE);
  logic  [TIME_W-1:0] prev_time    = '0;
  int                 groups_seen  = 0;
  int                 learned_size = 1;
  int                 group_count  = 0;
  longint             held_result  = longint'(MINUS_ONE);
  bit                 held_valid   = 1'b0;

  agg_result_t pending_results[$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          group_len;

  // Idling switches for each side, and the token that asks for a long hold-off.
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int hold_token  = 0;
  int hold_taken  = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  function automatic longint sat48(longint x);
    if (x > longint'(VAL_MAX)) return longint'(VAL_MAX);
    if (x < longint'(VAL_MIN)) return longint'(VAL_MIN);
    return x;
  endfunction

  // Multiply by an unsigned Q16.16 factor: work on the magnitude, truncate
  // towards zero, saturate to 48 bits signed.
  function automatic longint scale_q(longint x, logic [FACT_W-1:0] f);
    longint unsigned mag, lo, hi, r;
    bit neg;
    neg = (x < 0);
    mag = neg ? -x : x;
    lo  = (mag & 64'hFFFF_FFFF) * 64'(f);
    hi  = (mag >> 32) * 64'(f);
    if ((hi >> (15 + FRAC_BITS)) != 0) r = 64'h8000_0000_0000;
    else r = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
    if (neg) return (r >= 64'h8000_0000_0000) ? longint'(VAL_MIN) : -longint'(r);
    return (r > 64'h7FFF_FFFF_FFFF) ? longint'(VAL_MAX) : longint'(r);
  endfunction

  function automatic bit energy_known();
    return !cfg_model.is_energy || cfg_model.energy_unit != 0;
  endfunction

  function automatic longint report_scaled(longint x);
    if (cfg_model.is_energy && cfg_model.energy_unit != 0) x = scale_q(x, cfg_model.energy_unit);
    return scale_q(x, cfg_model.scale_factor);
  endfunction

  // Advance the grouping state by one sample and work out the result beat.
  function automatic agg_result_t predict_result(logic signed [SMP_W-1:0] value,
                                                 logic [TIME_W-1:0] stamp);
    longint      v = value;
    longint      src = 0;
    bit          fire = 1'b0;
    bit          counted;
    bit          done;
    agg_result_t r;
    if (stamp != prev_time) begin
      // fresh timestamp: restart the fold
      acc_value = v;
      if (groups_seen < 2) groups_seen++;
      group_count = 1;
      if (groups_seen >= 2 && learned_size == 1) begin
        fire = 1'b1;
        src  = acc_value;
      end
    end else begin
      counted = 1'b0;
      if (group_count < int'(COUNT_TOP)) begin
        group_count++;
        counted = 1'b1;
      end
      if (groups_seen == 1) begin
        // still inside the first group: only learn its size
        if (learned_size < MAX_GROUP) learned_size++;
      end else begin
        done = counted && group_count == learned_size;
        case (cfg_model.fold_mode)
          FOLD_AVG: begin
            acc_value = sat48(acc_value + v);
            if (done) held_result = acc_value / longint'(learned_size);
          end
          FOLD_SUM: begin
            acc_value = sat48(acc_value + v);
            if (done) held_result = acc_value;
          end
          FOLD_MIN: begin
            if (acc_value > v) acc_value = v;
            if (done) held_result = acc_value;
          end
          default: begin
            if (acc_value < v) acc_value = v;
            if (done) held_result = acc_value;
          end
        endcase
        if (done) begin
          held_valid = 1'b1;
          fire = 1'b1;
          src  = held_result;
        end
      end
    end
    prev_time = stamp;

    fire = fire && cfg_model.emit_enable && energy_known();
    r.emit_valid   = fire;
    r.emit_value   = fire ? VAL_W'(report_scaled(src)) : '0;
    r.latest_value = VAL_W'(report_scaled(learned_size > 1 ? held_result : acc_value));
    r.latest_ready = groups_seen >= 2 && energy_known() && (learned_size <= 1 || held_valid);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_FOLD_MODE:   return DATA_W'(cfg_model.fold_mode);
      REG_IS_ENERGY:   return DATA_W'(cfg_model.is_energy);
      REG_ENERGY_UNIT: return DATA_W'(cfg_model.energy_unit);
      REG_SCALE:       return DATA_W'(cfg_model.scale_factor);
      default:         return DATA_W'(cfg_model.emit_enable);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SMP_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      default: return SMP_W'(int'($urandom_range(0, 20 << FRAC_BITS)) - (10 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [FACT_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SCALE_RESET;
      3:       return $urandom;
      default: return $urandom_range(1, 4 << FRAC_BITS);
    endcase
  endfunction

  // A timestamp that differs from the last one accepted: mostly a short step
  // forward, now and then anywhere in the 48-bit range.
  function automatic logic [TIME_W-1:0] next_stamp();
    logic [TIME_W-1:0] s;
    if ($urandom_range(0, 7) == 0) s = TIME_W'({$urandom, $urandom});
    else s = prev_time + TIME_W'($urandom_range(1, 1000));
    if (s == prev_time) s = s + 1'b1;
    return s;
  endfunction

  // Offer one sample beat, hold it until accepted, then record its expected result.
  task automatic send_sample(input logic signed [SMP_W-1:0] value,
                             input logic [TIME_W-1:0] stamp);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_sample_time  <= stamp;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_result(value, stamp));
    items_sent++;
  endtask

  task automatic send_group(input int len);
    logic [TIME_W-1:0] stamp;
    stamp = next_stamp();
    repeat (len) send_sample(rand_value(), stamp);
  endtask

  // Drop valid and wait for every outstanding result beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_register(input logic [2:0] idx);
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== reg_value(idx)) begin
      $error("register %0d: expected %0h, got %0h", idx, reg_value(idx), got);
      error_count++;
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FOLD_MODE:   cfg_model.fold_mode    = value[1:0];
      REG_IS_ENERGY:   cfg_model.is_energy    = value[0];
      REG_ENERGY_UNIT: cfg_model.energy_unit  = value;
      REG_SCALE:       cfg_model.scale_factor = value;
      default:         cfg_model.emit_enable  = value[0];
    endcase
    check_register(idx);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    for (int i = REG_FOLD_MODE; i <= REG_EMIT_ENABLE; i++) check_register(3'(i));
  endtask

  // The group size is learned once per reset, so pick a size above one here
  // and keep it for the whole run.
  task automatic test_first_samples();
    // first beat lands on the reset timestamp of zero and folds as a repeat
    send_sample(32'sh7FFF_FFFF, '0);
    group_len = $urandom_range(2, 3);
    send_sample(32'sh8000_0000, TIME_W'(1));
    repeat (group_len - 1) send_sample(rand_value(), TIME_W'(1));
  endtask

  task automatic test_fold_modes();
    logic [TIME_W-1:0] stamp;
    for (int m = FOLD_AVG; m <= FOLD_MAX; m++) begin
      wait_drained();
      cfg_write(REG_FOLD_MODE, DATA_W'(m));
      // put the top timestamp on the last group
      stamp = (m == FOLD_MAX) ? '1 : next_stamp();
      send_sample(32'sh7FFF_FFFF, stamp);
      send_sample(32'sh8000_0000, stamp);
      repeat (group_len - 2) send_sample(rand_value(), stamp);
    end
  endtask

  task automatic test_scaling_cases();
    logic [TIME_W-1:0] stamp;
    // largest scale on a large sum: saturate both outputs
    wait_drained();
    cfg_write(REG_FOLD_MODE, DATA_W'(FOLD_SUM));
    cfg_write(REG_SCALE, '1);
    stamp = next_stamp();
    repeat (group_len) send_sample(32'sh7FFF_FFFF, stamp);
    // energy counter with no unit yet: suppress emission and latest_ready
    wait_drained();
    cfg_write(REG_SCALE, '0);
    cfg_write(REG_IS_ENERGY, DATA_W'(1));
    stamp = next_stamp();
    send_sample(32'shFFFF_FFFF, stamp);
    repeat (group_len - 1) send_sample(32'sh0000_0000, stamp);
    // largest unit, unit scale
    wait_drained();
    cfg_write(REG_ENERGY_UNIT, '1);
    cfg_write(REG_SCALE, DATA_W'(SCALE_RESET));
    send_group(group_len);
    // emission disabled: latest still tracks the group
    wait_drained();
    cfg_write(REG_EMIT_ENABLE, '0);
    send_group(group_len);
    wait_drained();
    cfg_write(REG_EMIT_ENABLE, DATA_W'(1));
    cfg_write(REG_IS_ENERGY, '0);
  endtask

  // Repeat one timestamp past the top of the in-group counter.
  task automatic test_count_saturation();
    logic [TIME_W-1:0] stamp;
    stamp = next_stamp();
    repeat (int'(COUNT_TOP) + 3) send_sample(rand_value(), stamp);
  endtask

  // Hold the result side off for a long stretch while the input keeps coming,
  // so the block fills and stalls its input.
  task automatic test_backpressure();
    wait_drained();
    in_idle_on = 1'b0;
    hold_token <= hold_token + 1;
    repeat (4) send_group(group_len);
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase_end;
    int shape;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      cfg_write(REG_FOLD_MODE, DATA_W'($urandom_range(0, 3)));
      cfg_write(REG_IS_ENERGY, DATA_W'($urandom_range(0, 1)));
      cfg_write(REG_ENERGY_UNIT, pick_factor());
      cfg_write(REG_SCALE, pick_factor());
      cfg_write(REG_EMIT_ENABLE, DATA_W'($urandom_range(0, 4) != 0));
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      phase_end = items_sent + $urandom_range(30, 70);
      while (items_sent < phase_end) begin
        shape = $urandom_range(0, 9);
        if (shape < 7) send_group(group_len);
        else if (shape == 7) send_group($urandom_range(1, group_len - 1));
        else if (shape == 8) send_group(group_len + $urandom_range(1, 3));
        else if (shape == 9 && $urandom_range(0, 1) == 1) send_sample(rand_value(), prev_time);
        else send_sample(rand_value(), TIME_W'({$urandom, $urandom}));
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: take each beat, compare it with the oldest expectation, then
  // draw the stall for the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    agg_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_emit_valid !== want.emit_valid) begin
          $error("emit_valid: expected %0d, got %0d", want.emit_valid, out_emit_valid);
          error_count++;
        end
        if (out_emit_value !== want.emit_value) begin
          $error("emit_value: expected %0d, got %0d", want.emit_value, out_emit_value);
          error_count++;
        end
        if (out_latest_ready !== want.latest_ready) begin
          $error("latest_ready: expected %0d, got %0d", want.latest_ready, out_latest_ready);
          error_count++;
        end
        if (out_latest_value !== want.latest_value) begin
          $error("latest_value: expected %0d, got %0d", want.latest_value, out_latest_value);
          error_count++;
        end
      end
      stall_left = out_idle_on ? $urandom_range(0, 7) : 0;
    end
    // a fresh token starts the long hold-off, counted here
    if (hold_token != hold_taken) begin
      hold_taken = hold_token;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_first_samples();
    test_fold_modes();
    test_scaling_cases();
    test_count_saturation();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    // let any stray beat show itself before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
